// ----- hdl/sop_pkg.sv -----
// shared widths and constants for the sphere occlusion proxy pipeline
package sop_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NRM_W = 16;
    localparam int VIS_W = 17;
    localparam int OCC_W = 17;
    localparam int EMAG_W = 30;
    localparam int SUM_W = 62;
    localparam int LQ_W = 31;
    localparam int NN_W = 32;
    localparam int NL_W = 16;
    localparam int DOT_W = 48;
    localparam int GDEN_W = 47;
    localparam int FRAC_W = 16;
    localparam int SQ_STEPS = 31;
    localparam int NSQ_STEPS = 16;
    localparam logic [OCC_W-1:0] Q16_ONE = 17'd65536;
    localparam logic [OCC_W:0] Q16_THREE = 18'd196608;

endpackage

// ----- hdl/sphere_occlusion_proxy.sv -----
// top level of the sphere occlusion proxy pipeline
//
// input channel: in_valid with in_stall carries one pixel per transaction
// (sphere center and radius, surface point, normal, visibility weight).
// output channel: out_valid with out_stall carries the occlusion factor,
// Q1.16 with 65536 meaning unoccluded.
// one transaction is taken every cycle while the output is not stalled;
// the pipeline is built from the front stages, the 31 bit steps of the
// distance square root, the setup stages, the 16 quotient steps of the
// two ratio dividers and the multiplier stages.
// reset clears every valid bit; no result is pending after reset.
// while out_stall holds back a waiting result the whole pipeline freezes
// and in_stall is raised, so nothing is lost or repeated.
module sphere_occlusion_proxy
    import sop_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic [COORD_WIDTH-2:0]        radius,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic signed [NRM_W-1:0]       normal_x,
    input  logic signed [NRM_W-1:0]       normal_y,
    input  logic signed [NRM_W-1:0]       normal_z,
    input  logic [VIS_W-1:0]              visibility,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [OCC_W-1:0]              occlusion
);

    localparam int CW = COORD_WIDTH;
    localparam int SW = $clog2(CW + 2);
    localparam int XW = CW + 3;
    localparam int SH_W = LQ_W + CW;

    logic en;

    logic                    sq_v    [0:SQ_STEPS];
    logic [SUM_W-1:0]        sq_rem  [0:SQ_STEPS];
    logic [SUM_W-1:0]        sq_root [0:SQ_STEPS];
    logic [NN_W-1:0]         sq_nrem [0:SQ_STEPS];
    logic [NN_W-1:0]         sq_nroot[0:SQ_STEPS];
    logic signed [DOT_W-1:0] sq_dot  [0:SQ_STEPS];
    logic [SW-1:0]           sq_s    [0:SQ_STEPS];
    logic [CW-2:0]           sq_r    [0:SQ_STEPS];
    logic [VIS_W-1:0]        sq_vis  [0:SQ_STEPS];

    logic                    dv_v    [0:FRAC_W];
    logic                    dv_xrun [0:FRAC_W];
    logic [XW-1:0]           dv_xrem [0:FRAC_W];
    logic [XW-1:0]           dv_xden [0:FRAC_W];
    logic [OCC_W-1:0]        dv_xq   [0:FRAC_W];
    logic                    dv_grun [0:FRAC_W];
    logic [DOT_W-1:0]        dv_grem [0:FRAC_W];
    logic [GDEN_W-1:0]       dv_gden [0:FRAC_W];
    logic [OCC_W-1:0]        dv_gq   [0:FRAC_W];
    logic [VIS_W-1:0]        dv_vis  [0:FRAC_W];

    logic [LQ_W-1:0]         lq;
    logic [NL_W-1:0]         nl;
    logic [SH_W-1:0]         sh;

    logic [1:0]              t_v_reg;
    logic signed [XW-1:0]    numx_reg;
    logic [XW-1:0]           denx_reg;
    logic [GDEN_W-1:0]       deng_reg;
    logic                    rz_reg;
    logic                    lqz_reg;
    logic                    nlz_reg;
    logic signed [DOT_W-1:0] dot_t_reg;
    logic [VIS_W-1:0]        vis_t_reg;

    logic                    xrun_next;
    logic [XW-1:0]           xrem_next;
    logic [OCC_W-1:0]        xq_next;
    logic                    grun_next;
    logic [DOT_W-1:0]        grem_next;
    logic [OCC_W-1:0]        gq_next;
    logic                    xrun_reg;
    logic [XW-1:0]           xrem_reg;
    logic [XW-1:0]           xden_reg;
    logic [OCC_W-1:0]        xq_reg;
    logic                    grun_reg;
    logic [DOT_W-1:0]        grem_reg;
    logic [GDEN_W-1:0]       gden_reg;
    logic [OCC_W-1:0]        gq_reg;
    logic [VIS_W-1:0]        vis_d_reg;

    assign en = !(out_valid && out_stall);
    assign in_stall = !en;

    sop_front #(.CW(CW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .radius     (radius),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .visibility (visibility),
        .f_valid    (sq_v[0]),
        .f_sum      (sq_rem[0]),
        .f_nn       (sq_nrem[0]),
        .f_dot      (sq_dot[0]),
        .f_shift    (sq_s[0]),
        .f_radius   (sq_r[0]),
        .f_vis      (sq_vis[0])
    );

    assign sq_root[0] = '0;
    assign sq_nroot[0] = '0;

    generate
        for (genvar i = 0; i < SQ_STEPS; i++)
        begin : g_sqrt
            sop_sqrt_stage #(.CW(CW), .IDX(i)) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .v_in      (sq_v[i]),
                .rem_in    (sq_rem[i]),
                .root_in   (sq_root[i]),
                .nrem_in   (sq_nrem[i]),
                .nroot_in  (sq_nroot[i]),
                .dot_in    (sq_dot[i]),
                .s_in      (sq_s[i]),
                .r_in      (sq_r[i]),
                .vis_in    (sq_vis[i]),
                .v_out     (sq_v[i+1]),
                .rem_out   (sq_rem[i+1]),
                .root_out  (sq_root[i+1]),
                .nrem_out  (sq_nrem[i+1]),
                .nroot_out (sq_nroot[i+1]),
                .dot_out   (sq_dot[i+1]),
                .s_out     (sq_s[i+1]),
                .r_out     (sq_r[i+1]),
                .vis_out   (sq_vis[i+1])
            );
        end
    endgenerate

    assign lq = sq_root[SQ_STEPS][LQ_W-1:0];
    assign nl = sq_nroot[SQ_STEPS][NL_W-1:0];
    assign sh = SH_W'(lq) << (sq_s[SQ_STEPS] + 1'b1);

    // ratio setup: numerators, denominators and clamped cases
    always_comb
    begin
        xrun_next = 1'b0;
        xrem_next = '0;
        xq_next = '0;
        if (rz_reg)
        begin
            xq_next = Q16_ONE;
        end
        else if (numx_reg <= 0)
        begin
            xq_next = '0;
        end
        else if (XW'(numx_reg) >= denx_reg)
        begin
            xq_next = Q16_ONE;
        end
        else
        begin
            xrun_next = 1'b1;
            xrem_next = XW'(numx_reg);
        end
        grun_next = 1'b0;
        grem_next = '0;
        gq_next = '0;
        if (lqz_reg || nlz_reg || dot_t_reg <= 0)
        begin
            gq_next = '0;
        end
        else if (DOT_W'(dot_t_reg) >= DOT_W'(deng_reg))
        begin
            gq_next = Q16_ONE;
        end
        else
        begin
            grun_next = 1'b1;
            grem_next = DOT_W'(dot_t_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_v_reg <= '0;
        end
        else if (en)
        begin
            t_v_reg <= {t_v_reg[0], sq_v[SQ_STEPS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg <= $signed(XW'(sh)) - $signed(XW'(sq_r[SQ_STEPS]));
            denx_reg <= XW'({sq_r[SQ_STEPS], 3'b000}) - XW'(sq_r[SQ_STEPS]);
            deng_reg <= GDEN_W'(nl) * GDEN_W'(lq);
            rz_reg <= (sq_r[SQ_STEPS] == '0);
            lqz_reg <= (lq == '0);
            nlz_reg <= (nl == '0);
            dot_t_reg <= sq_dot[SQ_STEPS];
            vis_t_reg <= sq_vis[SQ_STEPS];

            xrun_reg <= xrun_next;
            xrem_reg <= xrem_next;
            xden_reg <= denx_reg;
            xq_reg <= xq_next;
            grun_reg <= grun_next;
            grem_reg <= grem_next;
            gden_reg <= deng_reg;
            gq_reg <= gq_next;
            vis_d_reg <= vis_t_reg;
        end
    end

    assign dv_v[0] = t_v_reg[1];
    assign dv_xrun[0] = xrun_reg;
    assign dv_xrem[0] = xrem_reg;
    assign dv_xden[0] = xden_reg;
    assign dv_xq[0] = xq_reg;
    assign dv_grun[0] = grun_reg;
    assign dv_grem[0] = grem_reg;
    assign dv_gden[0] = gden_reg;
    assign dv_gq[0] = gq_reg;
    assign dv_vis[0] = vis_d_reg;

    generate
        for (genvar j = 0; j < FRAC_W; j++)
        begin : g_div
            sop_div_stage #(.CW(CW), .IDX(j)) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .v_in     (dv_v[j]),
                .xrun_in  (dv_xrun[j]),
                .xrem_in  (dv_xrem[j]),
                .xden_in  (dv_xden[j]),
                .xq_in    (dv_xq[j]),
                .grun_in  (dv_grun[j]),
                .grem_in  (dv_grem[j]),
                .gden_in  (dv_gden[j]),
                .gq_in    (dv_gq[j]),
                .vis_in   (dv_vis[j]),
                .v_out    (dv_v[j+1]),
                .xrun_out (dv_xrun[j+1]),
                .xrem_out (dv_xrem[j+1]),
                .xden_out (dv_xden[j+1]),
                .xq_out   (dv_xq[j+1]),
                .grun_out (dv_grun[j+1]),
                .grem_out (dv_grem[j+1]),
                .gden_out (dv_gden[j+1]),
                .gq_out   (dv_gq[j+1]),
                .vis_out  (dv_vis[j+1])
            );
        end
    endgenerate

    sop_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .v_in    (dv_v[FRAC_W]),
        .x_in    (dv_xq[FRAC_W]),
        .g_in    (dv_gq[FRAC_W]),
        .vis_in  (dv_vis[FRAC_W]),
        .v_out   (out_valid),
        .occ_out (occlusion)
    );

endmodule

// ----- hdl/sop_front.sv -----
// front stages: differences, range shift, squares, dot product and sums
module sop_front
    import sop_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    localparam int SW = $clog2(CW + 2)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [CW-1:0]    center_x,
    input  logic signed [CW-1:0]    center_y,
    input  logic signed [CW-1:0]    center_z,
    input  logic [CW-2:0]           radius,
    input  logic signed [CW-1:0]    point_x,
    input  logic signed [CW-1:0]    point_y,
    input  logic signed [CW-1:0]    point_z,
    input  logic signed [NRM_W-1:0] normal_x,
    input  logic signed [NRM_W-1:0] normal_y,
    input  logic signed [NRM_W-1:0] normal_z,
    input  logic [VIS_W-1:0]        visibility,
    output logic                    f_valid,
    output logic [SUM_W-1:0]        f_sum,
    output logic [NN_W-1:0]         f_nn,
    output logic signed [DOT_W-1:0] f_dot,
    output logic [SW-1:0]           f_shift,
    output logic [CW-2:0]           f_radius,
    output logic [VIS_W-1:0]        f_vis
);

    logic [5:0] v_reg;

    // stage 1
    logic signed [CW:0]       d1_reg [0:2];
    logic signed [CW:0]       d1_next [0:2];
    logic signed [NRM_W-1:0]  n1_reg [0:2];
    logic [CW-2:0]            r1_reg;
    logic [VIS_W-1:0]         vis1_reg;
    logic [VIS_W-1:0]         vis1_next;

    // stage 2
    logic [CW:0]              m2_reg [0:2];
    logic [CW:0]              m2_next [0:2];
    logic [2:0]               sg2_reg;
    logic [CW:0]              or2_next;
    logic [CW:0]              or2_reg;
    logic signed [NRM_W-1:0]  n2_reg [0:2];
    logic [CW-2:0]            r2_reg;
    logic [VIS_W-1:0]         vis2_reg;

    // stage 3
    logic [CW:0]              m3_reg [0:2];
    logic [2:0]               sg3_reg;
    logic [SW-1:0]            s3_reg;
    logic [SW-1:0]            s3_next;
    logic signed [NRM_W-1:0]  n3_reg [0:2];
    logic [CW-2:0]            r3_reg;
    logic [VIS_W-1:0]         vis3_reg;

    // stage 4
    logic [EMAG_W-1:0]        em4_reg [0:2];
    logic [EMAG_W-1:0]        em4_next [0:2];
    logic signed [EMAG_W:0]   e4_reg [0:2];
    logic [NN_W-2:0]          nsq4_reg [0:2];
    logic signed [NRM_W-1:0]  n4_reg [0:2];
    logic [SW-1:0]            s4_reg;
    logic [CW-2:0]            r4_reg;
    logic [VIS_W-1:0]         vis4_reg;

    // stage 5
    logic [2*EMAG_W-1:0]      sq5_reg [0:2];
    logic signed [NRM_W+EMAG_W:0] p5_reg [0:2];
    logic [NN_W-1:0]          nn5_reg;
    logic [SW-1:0]            s5_reg;
    logic [CW-2:0]            r5_reg;
    logic [VIS_W-1:0]         vis5_reg;

    // stage 6
    logic [SUM_W-1:0]         sum6_reg;
    logic signed [DOT_W-1:0]  dot6_reg;
    logic [NN_W-1:0]          nn6_reg;
    logic [SW-1:0]            s6_reg;
    logic [CW-2:0]            r6_reg;
    logic [VIS_W-1:0]         vis6_reg;

    always_comb
    begin
        d1_next[0] = {center_x[CW-1], center_x} - {point_x[CW-1], point_x};
        d1_next[1] = {center_y[CW-1], center_y} - {point_y[CW-1], point_y};
        d1_next[2] = {center_z[CW-1], center_z} - {point_z[CW-1], point_z};
        vis1_next = (visibility > Q16_ONE) ? Q16_ONE : visibility;
        for (int i = 0; i < 3; i++)
        begin
            m2_next[i] = d1_reg[i][CW] ? (~d1_reg[i] + 1'b1) : d1_reg[i];
        end
        or2_next = m2_next[0] | m2_next[1] | m2_next[2];
        s3_next = '0;
        for (int k = EMAG_W; k <= CW; k++)
        begin
            if (or2_reg[k])
            begin
                s3_next = SW'(k - EMAG_W + 1);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            em4_next[i] = EMAG_W'(m3_reg[i] >> s3_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= d1_next;
            n1_reg[0] <= normal_x;
            n1_reg[1] <= normal_y;
            n1_reg[2] <= normal_z;
            r1_reg <= radius;
            vis1_reg <= vis1_next;

            m2_reg <= m2_next;
            sg2_reg <= {d1_reg[2][CW], d1_reg[1][CW], d1_reg[0][CW]};
            or2_reg <= or2_next;
            n2_reg <= n1_reg;
            r2_reg <= r1_reg;
            vis2_reg <= vis1_reg;

            m3_reg <= m2_reg;
            sg3_reg <= sg2_reg;
            s3_reg <= s3_next;
            n3_reg <= n2_reg;
            r3_reg <= r2_reg;
            vis3_reg <= vis2_reg;

            for (int i = 0; i < 3; i++)
            begin
                em4_reg[i] <= em4_next[i];
                e4_reg[i] <= sg3_reg[i] ? -$signed({1'b0, em4_next[i]})
                                        : $signed({1'b0, em4_next[i]});
                nsq4_reg[i] <= (NN_W-1)'(n3_reg[i] * n3_reg[i]);
            end
            n4_reg <= n3_reg;
            s4_reg <= s3_reg;
            r4_reg <= r3_reg;
            vis4_reg <= vis3_reg;

            for (int i = 0; i < 3; i++)
            begin
                sq5_reg[i] <= em4_reg[i] * em4_reg[i];
                p5_reg[i] <= n4_reg[i] * e4_reg[i];
            end
            nn5_reg <= NN_W'(nsq4_reg[0]) + NN_W'(nsq4_reg[1]) + NN_W'(nsq4_reg[2]);
            s5_reg <= s4_reg;
            r5_reg <= r4_reg;
            vis5_reg <= vis4_reg;

            sum6_reg <= SUM_W'(sq5_reg[0]) + SUM_W'(sq5_reg[1]) + SUM_W'(sq5_reg[2]);
            dot6_reg <= DOT_W'(p5_reg[0]) + DOT_W'(p5_reg[1]) + DOT_W'(p5_reg[2]);
            nn6_reg <= nn5_reg;
            s6_reg <= s5_reg;
            r6_reg <= r5_reg;
            vis6_reg <= vis5_reg;
        end
    end

    assign f_valid = v_reg[5];
    assign f_sum = sum6_reg;
    assign f_nn = nn6_reg;
    assign f_dot = dot6_reg;
    assign f_shift = s6_reg;
    assign f_radius = r6_reg;
    assign f_vis = vis6_reg;

endmodule

// ----- hdl/sop_sqrt_stage.sv -----
// one bit step of the distance square root and, in the last NSQ_STEPS stages, of the normal length root
module sop_sqrt_stage
    import sop_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int IDX = 0,
    localparam int SW = $clog2(CW + 2)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    v_in,
    input  logic [SUM_W-1:0]        rem_in,
    input  logic [SUM_W-1:0]        root_in,
    input  logic [NN_W-1:0]         nrem_in,
    input  logic [NN_W-1:0]         nroot_in,
    input  logic signed [DOT_W-1:0] dot_in,
    input  logic [SW-1:0]           s_in,
    input  logic [CW-2:0]           r_in,
    input  logic [VIS_W-1:0]        vis_in,
    output logic                    v_out,
    output logic [SUM_W-1:0]        rem_out,
    output logic [SUM_W-1:0]        root_out,
    output logic [NN_W-1:0]         nrem_out,
    output logic [NN_W-1:0]         nroot_out,
    output logic signed [DOT_W-1:0] dot_out,
    output logic [SW-1:0]           s_out,
    output logic [CW-2:0]           r_out,
    output logic [VIS_W-1:0]        vis_out
);

    localparam int K = SQ_STEPS - 1 - IDX;
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * K);

    logic             v_reg;
    logic [SUM_W:0]   trial;
    logic [SUM_W-1:0] rem_next;
    logic [SUM_W-1:0] root_next;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] root_reg;
    logic [NN_W-1:0]  nrem_next;
    logic [NN_W-1:0]  nroot_next;
    logic [NN_W-1:0]  nrem_reg;
    logic [NN_W-1:0]  nroot_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [SW-1:0]    s_reg;
    logic [CW-2:0]    r_reg;
    logic [VIS_W-1:0] vis_reg;

    always_comb
    begin
        trial = {1'b0, root_in} + {1'b0, BIT};
        if ({1'b0, rem_in} >= trial)
        begin
            rem_next = rem_in - trial[SUM_W-1:0];
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            rem_next = rem_in;
            root_next = root_in >> 1;
        end
    end

    generate
        if (IDX >= SQ_STEPS - NSQ_STEPS)
        begin : g_nsqrt
            localparam logic [NN_W-1:0] NBIT = NN_W'(1) << (2 * K);
            logic [NN_W:0] ntrial;
            always_comb
            begin
                ntrial = {1'b0, nroot_in} + {1'b0, NBIT};
                if ({1'b0, nrem_in} >= ntrial)
                begin
                    nrem_next = nrem_in - ntrial[NN_W-1:0];
                    nroot_next = (nroot_in >> 1) + NBIT;
                end
                else
                begin
                    nrem_next = nrem_in;
                    nroot_next = nroot_in >> 1;
                end
            end
        end
        else
        begin : g_npass
            always_comb
            begin
                nrem_next = nrem_in;
                nroot_next = nroot_in;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            root_reg <= root_next;
            nrem_reg <= nrem_next;
            nroot_reg <= nroot_next;
            dot_reg <= dot_in;
            s_reg <= s_in;
            r_reg <= r_in;
            vis_reg <= vis_in;
        end
    end

    assign v_out = v_reg;
    assign rem_out = rem_reg;
    assign root_out = root_reg;
    assign nrem_out = nrem_reg;
    assign nroot_out = nroot_reg;
    assign dot_out = dot_reg;
    assign s_out = s_reg;
    assign r_out = r_reg;
    assign vis_out = vis_reg;

endmodule

// ----- hdl/sop_div_stage.sv -----
// one quotient bit of the distance ratio and the cosine ratio
module sop_div_stage
    import sop_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int IDX = 0,
    localparam int XW = CW + 3
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                v_in,
    input  logic                xrun_in,
    input  logic [XW-1:0]       xrem_in,
    input  logic [XW-1:0]       xden_in,
    input  logic [OCC_W-1:0]    xq_in,
    input  logic                grun_in,
    input  logic [DOT_W-1:0]    grem_in,
    input  logic [GDEN_W-1:0]   gden_in,
    input  logic [OCC_W-1:0]    gq_in,
    input  logic [VIS_W-1:0]    vis_in,
    output logic                v_out,
    output logic                xrun_out,
    output logic [XW-1:0]       xrem_out,
    output logic [XW-1:0]       xden_out,
    output logic [OCC_W-1:0]    xq_out,
    output logic                grun_out,
    output logic [DOT_W-1:0]    grem_out,
    output logic [GDEN_W-1:0]   gden_out,
    output logic [OCC_W-1:0]    gq_out,
    output logic [VIS_W-1:0]    vis_out
);

    localparam logic [OCC_W-1:0] QBIT = OCC_W'(1) << (FRAC_W - 1 - IDX);

    logic             v_reg;
    logic [XW-1:0]    xsh;
    logic [XW-1:0]    xrem_next;
    logic [OCC_W-1:0] xq_next;
    logic [DOT_W-1:0] gsh;
    logic [DOT_W-1:0] grem_next;
    logic [OCC_W-1:0] gq_next;
    logic             xrun_reg;
    logic [XW-1:0]    xrem_reg;
    logic [XW-1:0]    xden_reg;
    logic [OCC_W-1:0] xq_reg;
    logic             grun_reg;
    logic [DOT_W-1:0] grem_reg;
    logic [GDEN_W-1:0] gden_reg;
    logic [OCC_W-1:0] gq_reg;
    logic [VIS_W-1:0] vis_reg;

    always_comb
    begin
        xsh = xrem_in << 1;
        xrem_next = xrem_in;
        xq_next = xq_in;
        if (xrun_in)
        begin
            xrem_next = xsh;
            if (xsh >= xden_in)
            begin
                xrem_next = xsh - xden_in;
                xq_next = xq_in | QBIT;
            end
        end
        gsh = grem_in << 1;
        grem_next = grem_in;
        gq_next = gq_in;
        if (grun_in)
        begin
            grem_next = gsh;
            if (gsh >= DOT_W'(gden_in))
            begin
                grem_next = gsh - DOT_W'(gden_in);
                gq_next = gq_in | QBIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xrun_reg <= xrun_in;
            xrem_reg <= xrem_next;
            xden_reg <= xden_in;
            xq_reg <= xq_next;
            grun_reg <= grun_in;
            grem_reg <= grem_next;
            gden_reg <= gden_in;
            gq_reg <= gq_next;
            vis_reg <= vis_in;
        end
    end

    assign v_out = v_reg;
    assign xrun_out = xrun_reg;
    assign xrem_out = xrem_reg;
    assign xden_out = xden_reg;
    assign xq_out = xq_reg;
    assign grun_out = grun_reg;
    assign grem_out = grem_reg;
    assign gden_out = gden_reg;
    assign gq_out = gq_reg;
    assign vis_out = vis_reg;

endmodule

// ----- hdl/sop_back.sv -----
// back stages: smoothstep, occlusion blend and visibility weighting
module sop_back
    import sop_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             v_in,
    input  logic [OCC_W-1:0] x_in,
    input  logic [OCC_W-1:0] g_in,
    input  logic [VIS_W-1:0] vis_in,
    output logic             v_out,
    output logic [OCC_W-1:0] occ_out
);

    logic [3:0]         v_reg;
    logic [2*OCC_W-1:0] xx_prod;
    logic [OCC_W-1:0]   x2_reg;
    logic [OCC_W:0]     t_reg;
    logic [OCC_W-1:0]   g1_reg;
    logic [VIS_W-1:0]   vis1_reg;
    logic [2*OCC_W:0]   o_prod;
    logic [OCC_W-1:0]   o_reg;
    logic [OCC_W-1:0]   g2_reg;
    logic [VIS_W-1:0]   vis2_reg;
    logic [OCC_W-1:0]   om;
    logic [2*OCC_W-1:0] a_prod;
    logic [OCC_W-1:0]   a_reg;
    logic [VIS_W-1:0]   vis3_reg;
    logic [2*OCC_W-1:0] w_prod;
    logic [OCC_W-1:0]   occ_reg;

    always_comb
    begin
        xx_prod = x_in * x_in;
        o_prod = x2_reg * t_reg;
        om = Q16_ONE - o_reg;
        a_prod = om * g2_reg;
        w_prod = a_reg * vis3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], v_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg <= xx_prod[2*FRAC_W:FRAC_W];
            t_reg <= Q16_THREE - {x_in, 1'b0};
            g1_reg <= g_in;
            vis1_reg <= vis_in;
            o_reg <= o_prod[2*FRAC_W:FRAC_W];
            g2_reg <= g1_reg;
            vis2_reg <= vis1_reg;
            a_reg <= a_prod[2*FRAC_W:FRAC_W];
            vis3_reg <= vis2_reg;
            occ_reg <= Q16_ONE - w_prod[2*FRAC_W:FRAC_W];
        end
    end

    assign v_out = v_reg[3];
    assign occ_out = occ_reg;

endmodule

// ----- tb/sv/tb_sphere_occlusion_proxy.sv -----
// self-checking testbench for the sphere occlusion proxy pipeline
module tb_sphere_occlusion_proxy;
    import sop_pkg::*;

    localparam int CW = 32;

    typedef struct {
        logic signed [CW-1:0] cx, cy, cz;
        logic [CW-2:0]        rad;
        logic signed [CW-1:0] px, py, pz;
        logic signed [15:0]   nx, ny, nz;
        logic [16:0]          vis;
        int                   fixed_occ;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CW-1:0] center_x = '0, center_y = '0, center_z = '0;
    logic [CW-2:0] radius = '0;
    logic signed [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
    logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic [16:0] visibility = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [16:0] occlusion;

    logic [16:0] occ_expected[$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    logic done = 1'b0;

    always #4 clk = ~clk;

    sphere_occlusion_proxy dut (.*);

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] q16_ratio(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q = 0;
        rem = num;
        for (int i = 15; i >= 0; i--)
        begin
            rem = rem << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [16:0] occlusion_of(pixel_t p);
        longint d[3], e[3], n[3];
        logic [63:0] m, sum, nn, lq, nl, x, x2, o, g, a, r, vis, den;
        longint dot, num;
        int s;
        m = 0; sum = 0; nn = 0; dot = 0; s = 0;
        d[0] = longint'(p.cx) - longint'(p.px);
        d[1] = longint'(p.cy) - longint'(p.py);
        d[2] = longint'(p.cz) - longint'(p.pz);
        n[0] = longint'(p.nx); n[1] = longint'(p.ny); n[2] = longint'(p.nz);
        for (int i = 0; i < 3; i++)
            if ((d[i] < 0 ? -d[i] : d[i]) > m)
                m = d[i] < 0 ? -d[i] : d[i];
        r = 64'(p.rad);
        vis = (p.vis > 17'd65536) ? 64'd65536 : 64'(p.vis);
        while ((m >> s) >= (64'd1 << 30))
            s++;
        for (int i = 0; i < 3; i++)
        begin
            e[i] = d[i] < 0 ? -((-d[i]) >>> s) : (d[i] >>> s);
            sum += e[i] * e[i];
            nn += n[i] * n[i];
            dot += n[i] * e[i];
        end
        lq = int_sqrt(sum);
        nl = int_sqrt(nn);
        if (r == 0)
            x = 65536;
        else
        begin
            den = 7 * r;
            num = longint'(lq << (s + 1)) - longint'(r);
            if (num <= 0)
                x = 0;
            else if (num >= den)
                x = 65536;
            else
                x = q16_ratio(num, den);
        end
        x2 = (x * x) >> 16;
        o = (x2 * (196608 - 2 * x)) >> 16;
        if (lq == 0 || nl == 0 || dot <= 0)
            g = 0;
        else
        begin
            den = nl * lq;
            if (dot >= den)
                g = 65536;
            else
                g = q16_ratio(dot, den);
        end
        a = ((65536 - o) * g) >> 16;
        return 17'(65536 - ((a * vis) >> 16));
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int base;
        int span;
        p.fixed_occ = -1;
        base = $urandom_range(0, 3);
        span = (base == 0) ? 32 : (base == 1) ? 24 : (base == 2) ? 16 : 12;
        p.px = $urandom >> (32 - span);
        p.py = $urandom >> (32 - span);
        p.pz = $urandom >> (32 - span);
        if ($urandom_range(0, 1)) p.px = -p.px;
        if ($urandom_range(0, 1)) p.py = -p.py;
        if ($urandom_range(0, 1)) p.pz = -p.pz;
        p.cx = p.px + ($signed($urandom) >>> (32 - span + 2));
        p.cy = p.py + ($signed($urandom) >>> (32 - span + 2));
        p.cz = p.pz + ($signed($urandom) >>> (32 - span + 2));
        p.rad = 31'($urandom >> (33 - span + $urandom_range(0, 4)));
        if ($urandom_range(0, 9) == 0)
        begin
            p.cx = $urandom; p.cy = $urandom; p.cz = $urandom;
            p.px = $urandom; p.py = $urandom; p.pz = $urandom;
            p.rad = 31'($urandom);
        end
        p.nx = 16'($urandom); p.ny = 16'($urandom); p.nz = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
            p.nx = $signed(p.nx) >>> $urandom_range(0, 15);
        p.vis = $urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
        return p;
    endfunction

    function automatic pixel_t mk(longint cx, longint cy, longint cz, longint rad,
                                  longint px, longint py, longint pz,
                                  int nx, int ny, int nz, int vis, int occ);
        pixel_t p;
        p.cx = 32'(cx); p.cy = 32'(cy); p.cz = 32'(cz); p.rad = 31'(rad);
        p.px = 32'(px); p.py = 32'(py); p.pz = 32'(pz);
        p.nx = 16'(nx); p.ny = 16'(ny); p.nz = 16'(nz); p.vis = 17'(vis);
        p.fixed_occ = occ;
        return p;
    endfunction

    task automatic send_pixel(pixel_t p);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        center_x <= p.cx; center_y <= p.cy; center_z <= p.cz;
        radius <= p.rad;
        point_x <= p.px; point_y <= p.py; point_z <= p.pz;
        normal_x <= p.nx; normal_y <= p.ny; normal_z <= p.nz;
        visibility <= p.vis;
        occ_expected.push_back(p.fixed_occ >= 0 ? 17'(p.fixed_occ) : occlusion_of(p));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (occ_expected.size() == 0)
            begin
                $display("%0t unexpected transaction: expected none, actual %0d",
                         $time, occlusion);
                errors++;
            end
            else
            begin
                if (occlusion !== occ_expected[0])
                begin
                    $display("%0t occlusion mismatch: expected %0d, actual %0d",
                             $time, occ_expected[0], occlusion);
                    errors++;
                end
                void'(occ_expected.pop_front());
            end
        end
    end

    initial
    begin
        pixel_t directed[$];
        directed.push_back(mk(0, 0, 0, 256, 0, 0, 0, 16384, 0, 0, 65536, 65536));
        directed.push_back(mk(2560, 0, 0, 256, 0, 0, 0, 0, 0, 0, 65536, 65536));
        directed.push_back(mk(2560, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 65536, 65536));
        directed.push_back(mk(2560, 0, 0, 256, 0, 0, 0, -16384, 0, 0, 65536, 65536));
        directed.push_back(mk(300, 0, 0, 256, 0, 0, 0, 16384, 0, 0, 0, 65536));
        directed.push_back(mk(128, 0, 0, 256, 0, 0, 0, 16384, 0, 0, 65536, 0));
        directed.push_back(mk(128, 0, 0, 256, 0, 0, 0, 16384, 0, 0, 131071, 0));
        directed.push_back(mk(128, 0, 0, 256, 0, 0, 0, 32767, 32767, 32767, 65536, -1));
        directed.push_back(mk(128, 0, 0, 256, 0, 0, 0, -32768, -32768, -32768, 32768, -1));
        directed.push_back(mk(1000, 500, -300, 256, 0, 0, 0, 100, 50, -30, 40000, -1));
        directed.push_back(mk(2147483647, 2147483647, 2147483647, 2147483647,
                              -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                              16384, 16384, 16384, 65536, -1));
        directed.push_back(mk(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 1,
                              2147483647, 2147483647, 2147483647,
                              -16384, -16384, -16384, 65536, -1));
        directed.push_back(mk(-64'sd2147483648, 0, 0, 2147483647, 2147483647, 0, 0,
                              -1, 0, 0, 65535, -1));
        directed.push_back(mk(5000, 0, 0, 1000, 0, 0, 0, 8000, 8000, 0, 1, -1));
        directed.push_back(mk(3000, 3000, 3000, 500, 0, 0, 0, 0, 0, 32767, 65536, -1));
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
            send_pixel(directed[i]);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 61 : 24) : 0;
            recv_idle = (ph == 2) ? 61 : (ph == 3) ? 24 : 0;
            for (int i = 0; i < 385; i++)
                send_pixel(random_pixel());
            in_valid <= 1'b0;
            while (occ_expected.size() != 0)
                @(negedge clk);
        end
        send_idle = 0;
        recv_idle = 0;
        repeat (80) @(negedge clk);
        done = 1'b1;
    end

    initial
    begin
        wait (done);
        if (errors == 0 && occ_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
